@@ rtl/core/btr_pkg.sv @@
// Package of the boot transfer responder.
// Holds the transfer structs, command and acknowledgement codes, and the fixed constants.
// No dependencies.
package btr_pkg;

  localparam logic [15:0] HEADER_BYTES   = 16'd16;
  localparam logic [4:0]  FAST_ADVERTS   = 5'd20;
  localparam logic [15:0] SERVER_PORT_RST = 16'd33330;

  localparam int unsigned BUF_W   = 25;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_W   = 25;

  localparam logic [31:0] CMD_COMMAND   = 32'd1;
  localparam logic [31:0] CMD_SEND_FILE = 32'd2;
  localparam logic [31:0] CMD_DATA      = 32'd3;
  localparam logic [31:0] CMD_BOOT      = 32'd4;

  localparam logic [1:0] ACK_OK        = 2'd0;
  localparam logic [1:0] ACK_TOO_LARGE = 2'd1;
  localparam logic [1:0] ACK_BAD_CMD   = 2'd2;

  localparam logic [1:0] REARM_NONE = 2'd0;
  localparam logic [1:0] REARM_FAST = 2'd1;
  localparam logic [1:0] REARM_SLOW = 2'd2;

  localparam logic [1:0] ADVERT_ONE = 2'd1;

  localparam logic ACTION_PACKET = 1'b0;
  localparam logic ACTION_POLL   = 1'b1;

  localparam logic REG_BUFFER_SIZE = 1'b0;
  localparam logic REG_SERVER_PORT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] dest_port;
    logic [15:0] packet_len;
    logic [31:0] cookie;
    logic [31:0] command;
    logic [31:0] argument;
    logic        link_up;
    logic        timer_expired;
  } in_item_t;

  typedef struct packed {
    logic        send_ack;
    logic [1:0]  ack_code;
    logic [31:0] ack_cookie;
    logic [31:0] ack_arg;
    logic        store_enable;
    logic [24:0] store_offset;
    logic [15:0] store_len;
    logic [1:0]  advert_count;
    logic [1:0]  timer_rearm;
    logic        boot_ready;
    logic [24:0] boot_length;
  } out_item_t;

  typedef struct packed {
    logic [24:0] buffer_size;
    logic [15:0] server_port;
  } cfg_t;

  typedef struct packed {
    logic [31:0] prev_cookie;
    logic [31:0] prev_command;
    logic [31:0] prev_argument;
    logic [1:0]  prev_ack_code;
    logic [31:0] prev_ack_arg;
    logic [24:0] receive_offset;
    logic        boot_pending;
    logic        transfer_active;
    logic        link_online;
    logic [4:0]  fast_adverts_left;
  } state_t;

endpackage

@@ rtl/core/btr_packet_unit.sv @@
// Packet path of the boot transfer responder: port and header filter, repeat
// detection and command decode. Purely combinational; uses btr_pkg.
module btr_packet_unit import btr_pkg::*; #(
  parameter logic [15:0] HDR_BYTES = HEADER_BYTES
) (
  input  cfg_t      cfg_i,
  input  state_t    state_i,
  input  in_item_t  item_i,
  output out_item_t result_o,
  output state_t    state_o
);

  logic [15:0] len;
  logic [25:0] sum;
  logic        repeat_hit;
  logic        keep;
  logic [1:0]  code;
  logic [31:0] aarg;

  assign len = item_i.packet_len - HDR_BYTES;
  assign sum = {1'b0, state_i.receive_offset} + {10'd0, len};
  assign repeat_hit = (item_i.cookie == state_i.prev_cookie) &&
                      (item_i.command == state_i.prev_command) &&
                      (item_i.argument == state_i.prev_argument);

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    keep     = 1'b1;
    code     = ACK_OK;
    aarg     = '0;
    if ((item_i.dest_port == cfg_i.server_port) && (item_i.packet_len >= HDR_BYTES)) begin
      if (repeat_hit) begin
        state_o.transfer_active = 1'b1;
        result_o.send_ack   = 1'b1;
        result_o.ack_code   = state_i.prev_ack_code;
        result_o.ack_cookie = state_i.prev_cookie;
        result_o.ack_arg    = state_i.prev_ack_arg;
      end else begin
        case (item_i.command)
          CMD_COMMAND: begin
            keep = (len != '0);
          end
          CMD_SEND_FILE: begin
            keep = (len != '0);
            if (keep) begin
              state_o.receive_offset = '0;
            end
          end
          CMD_DATA: begin
            keep = (item_i.argument == {7'd0, state_i.receive_offset}) &&
                   (cfg_i.buffer_size != '0);
            aarg = item_i.argument;
            if (keep) begin
              if (sum > {1'b0, cfg_i.buffer_size}) begin
                code = ACK_TOO_LARGE;
              end else begin
                result_o.store_enable  = 1'b1;
                result_o.store_offset  = state_i.receive_offset;
                result_o.store_len     = len;
                state_o.receive_offset = sum[24:0];
              end
            end
          end
          CMD_BOOT: begin
            state_o.boot_pending = 1'b1;
          end
          default: begin
            code = ACK_BAD_CMD;
          end
        endcase
        if (keep) begin
          state_o.prev_cookie     = item_i.cookie;
          state_o.prev_command    = item_i.command;
          state_o.prev_argument   = item_i.argument;
          state_o.prev_ack_code   = code;
          state_o.prev_ack_arg    = aarg;
          state_o.transfer_active = 1'b1;
          result_o.send_ack   = 1'b1;
          result_o.ack_code   = code;
          result_o.ack_cookie = item_i.cookie;
          result_o.ack_arg    = aarg;
        end
      end
    end
  end

endmodule

@@ rtl/core/btr_poll_unit.sv @@
// Poll path of the boot transfer responder: link tracking, advertisement pacing
// and boot reporting. Purely combinational; uses btr_pkg.
module btr_poll_unit import btr_pkg::*; #(
  parameter logic [4:0] FAST_COUNT = FAST_ADVERTS
) (
  input  state_t    state_i,
  input  in_item_t  item_i,
  output out_item_t result_o,
  output state_t    state_o
);

  logic [4:0] fast_left;
  logic [1:0] adverts;
  logic [1:0] rearm;

  always_comb begin
    result_o  = '0;
    state_o   = state_i;
    fast_left = state_i.fast_adverts_left;
    adverts   = '0;
    rearm     = REARM_NONE;
    if (!item_i.link_up) begin
      state_o.link_online = 1'b0;
    end else begin
      if (!state_i.link_online) begin
        state_o.link_online = 1'b1;
        fast_left = FAST_COUNT;
        rearm     = REARM_FAST;
        adverts   = ADVERT_ONE;
      end
      if (item_i.timer_expired) begin
        if (fast_left != '0) begin
          fast_left = fast_left - 5'd1;
          rearm     = REARM_FAST;
        end else begin
          rearm = REARM_SLOW;
        end
        if (state_i.transfer_active) begin
          state_o.transfer_active = 1'b0;
        end else begin
          adverts = adverts + ADVERT_ONE;
        end
      end
      state_o.fast_adverts_left = fast_left;
      result_o.advert_count = adverts;
      result_o.timer_rearm  = rearm;
      if (state_i.boot_pending) begin
        state_o.boot_pending = 1'b0;
        result_o.boot_ready  = 1'b1;
        result_o.boot_length = state_i.receive_offset;
      end
    end
  end

endmodule

@@ rtl/core/boot_transfer_responder.sv @@
// Top level of the boot transfer responder: input register, state, result register.
// Instantiates btr_packet_unit and btr_poll_unit; uses btr_pkg.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o    in_item_i (in_item_t)
//   out       output     out_valid_o / out_ready_i  out_item_o (out_item_t)
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// Every item's result is loaded into the result register from the input register,
// and an item can be taken every cycle while the result register is not stalled.
// The input register feeds the packet and poll logic, which updates the state and
// loads the result register in the same cycle. A stalled result holds the result
// register, then the input register, and then in_ready_o drops. Reset clears the
// state, sets server_port to 33330 and buffer_size to zero.
module boot_transfer_responder import btr_pkg::*; #(
  parameter logic [15:0] HDR_BYTES  = HEADER_BYTES,
  parameter logic [4:0]  FAST_COUNT = FAST_ADVERTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  cfg_t      cfg_q, cfg_d;
  state_t    state_q, state_d;

  out_item_t pkt_result, poll_result;
  state_t    pkt_state, poll_state;
  logic      out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  btr_packet_unit #(
    .HDR_BYTES (HDR_BYTES)
  ) u_packet (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .result_o (pkt_result),
    .state_o  (pkt_state)
  );

  btr_poll_unit #(
    .FAST_COUNT (FAST_COUNT)
  ) u_poll (
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .result_o (poll_result),
    .state_o  (poll_state)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    state_d = state_q;
    if (s1_fire) begin
      state_d = (s1_item_q.action == ACTION_POLL) ? poll_state : pkt_state;
    end
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BUFFER_SIZE: cfg_d.buffer_size = cfg_data_i;
        REG_SERVER_PORT: cfg_d.server_port = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q             <= '0;
      cfg_q.buffer_size   <= '0;
      cfg_q.server_port   <= SERVER_PORT_RST;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q <= (s1_item_q.action == ACTION_POLL) ? poll_result : pkt_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/btr_checker.sv @@
// Port checker of the boot transfer responder and its bind statement.
// Uses btr_pkg; attaches to boot_transfer_responder.
module btr_checker import btr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o,
  input logic      cfg_we_i,
  input logic      cfg_index_i,
  input logic [24:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result changed or vanished while stalled.");

  a_ack_not_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.send_ack |->
      out_item_o.advert_count == 2'd0 && out_item_o.timer_rearm == REARM_NONE &&
      !out_item_o.boot_ready)
    else $error("Acknowledgement mixed with poll fields.");

  a_store_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.store_enable |->
      out_item_o.send_ack && out_item_o.ack_code == ACK_OK &&
      out_item_o.ack_arg == {7'd0, out_item_o.store_offset})
    else $error("Store without matching data acknowledgement.");

  a_advert_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.advert_count != 2'd0 |-> out_item_o.timer_rearm != REARM_NONE)
    else $error("Advertisement without timer rearm.");

endmodule

bind boot_transfer_responder btr_checker u_btr_checker (.*);

@@ dv/btr_response_checker.sv @@
// Scoreboard for the boot transfer responder: watches the item, result and register ports,
// predicts every result from its own copy of the responder state and compares field by field.
// Depends on btr_pkg.
module btr_response_checker import btr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [24:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [24:0] buf_size;
  logic [15:0] srv_port;

  logic [31:0] hist_cookie;
  logic [31:0] last_command;
  logic [31:0] last_argument;
  logic [1:0]  last_code;
  logic [31:0] last_reply_arg;
  logic [24:0] rx_offset;
  logic        boot_req;
  logic        xfer_active;
  logic        link_on;
  logic [4:0]  fast_left;

  out_item_t pending_responses[$];
  out_item_t oldest;

  function automatic out_item_t predict_response(in_item_t it);
    out_item_t   r;
    logic [31:0] payload;
    logic [31:0] reply_arg;
    logic [1:0]  code;
    logic [1:0]  adverts;
    logic [1:0]  rearm;
    r = '0;
    if (it.action == ACTION_PACKET) begin
      if (it.dest_port != srv_port || it.packet_len < HEADER_BYTES) return r;
      payload = {16'd0, it.packet_len} - {16'd0, HEADER_BYTES};
      if (it.cookie == hist_cookie && it.command == last_command &&
          it.argument == last_argument) begin
        xfer_active = 1'b1;
        r.send_ack = 1'b1;
        r.ack_code = last_code;
        r.ack_cookie = hist_cookie;
        r.ack_arg = last_reply_arg;
        return r;
      end
      code = ACK_OK;
      reply_arg = '0;
      case (it.command)
        CMD_COMMAND: begin
          if (payload == 0) return r;
        end
        CMD_SEND_FILE: begin
          if (payload == 0) return r;
          rx_offset = '0;
        end
        CMD_DATA: begin
          if (it.argument != {7'd0, rx_offset} || buf_size == 0) return r;
          reply_arg = it.argument;
          if ({7'd0, rx_offset} + payload > {7'd0, buf_size}) begin
            code = ACK_TOO_LARGE;
          end else begin
            r.store_enable = 1'b1;
            r.store_offset = rx_offset;
            r.store_len = payload[15:0];
            rx_offset = rx_offset + payload[24:0];
          end
        end
        CMD_BOOT: begin
          boot_req = 1'b1;
        end
        default: begin
          code = ACK_BAD_CMD;
        end
      endcase
      hist_cookie = it.cookie;
      last_command = it.command;
      last_argument = it.argument;
      last_code = code;
      last_reply_arg = reply_arg;
      xfer_active = 1'b1;
      r.send_ack = 1'b1;
      r.ack_code = code;
      r.ack_cookie = it.cookie;
      r.ack_arg = reply_arg;
      return r;
    end
    if (!it.link_up) begin
      link_on = 1'b0;
      return r;
    end
    adverts = '0;
    rearm = REARM_NONE;
    if (!link_on) begin
      link_on = 1'b1;
      fast_left = FAST_ADVERTS;
      rearm = REARM_FAST;
      adverts = ADVERT_ONE;
    end
    if (it.timer_expired) begin
      if (fast_left != 0) begin
        fast_left = fast_left - 5'd1;
        rearm = REARM_FAST;
      end else begin
        rearm = REARM_SLOW;
      end
      if (xfer_active) begin
        xfer_active = 1'b0;
      end else begin
        adverts = adverts + 2'd1;
      end
    end
    r.advert_count = adverts;
    r.timer_rearm = rearm;
    if (boot_req) begin
      boot_req = 1'b0;
      r.boot_ready = 1'b1;
      r.boot_length = rx_offset;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result(out_item_t want, out_item_t got);
    check_field("send_ack", 32'(want.send_ack), 32'(got.send_ack));
    check_field("ack_code", 32'(want.ack_code), 32'(got.ack_code));
    check_field("ack_cookie", want.ack_cookie, got.ack_cookie);
    check_field("ack_arg", want.ack_arg, got.ack_arg);
    check_field("store_enable", 32'(want.store_enable), 32'(got.store_enable));
    check_field("store_offset", 32'(want.store_offset), 32'(got.store_offset));
    check_field("store_len", 32'(want.store_len), 32'(got.store_len));
    check_field("advert_count", 32'(want.advert_count), 32'(got.advert_count));
    check_field("timer_rearm", 32'(want.timer_rearm), 32'(got.timer_rearm));
    check_field("boot_ready", 32'(want.boot_ready), 32'(got.boot_ready));
    check_field("boot_length", 32'(want.boot_length), 32'(got.boot_length));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_responses.delete();
      buf_size = '0;
      srv_port = SERVER_PORT_RST;
      hist_cookie = '0;
      last_command = '0;
      last_argument = '0;
      last_code = ACK_OK;
      last_reply_arg = '0;
      rx_offset = '0;
      boot_req = 1'b0;
      xfer_active = 1'b0;
      link_on = 1'b0;
      fast_left = '0;
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_BUFFER_SIZE) begin
          buf_size = cfg_data_i;
        end else begin
          srv_port = cfg_data_i[15:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_responses.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_item_i);
        end else begin
          oldest = pending_responses.pop_front();
          compare_result(oldest, out_item_i);
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_responses.push_back(predict_response(in_item_i));
      end
      pending_o = pending_responses.size();
    end
  end

endmodule

@@ dv/tb_boot_transfer_responder.sv @@
// Top of the boot transfer responder testbench: clock, reset, register writes and item traffic.
// A directed opening is followed by random transfer sessions under several flow-control phases.
// Depends on btr_pkg, boot_transfer_responder and btr_response_checker.
module tb_boot_transfer_responder import btr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [24:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int quiet_cycles = 0;
  int idle_pct;
  int stall_pct;
  int items_sent;

  logic [24:0] cur_buf;
  logic [15:0] cur_port;
  logic [24:0] gen_offset;
  logic [31:0] next_cookie;
  logic        session_open;
  in_item_t    last_pkt;

  always #6 clk = ~clk;

  boot_transfer_responder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  btr_response_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t packet(logic [15:0] port, logic [15:0] len, logic [31:0] cookie,
                                      logic [31:0] cmd, logic [31:0] arg);
    in_item_t it;
    it.action = ACTION_PACKET;
    it.dest_port = port;
    it.packet_len = len;
    it.cookie = cookie;
    it.command = cmd;
    it.argument = arg;
    it.link_up = 1'($urandom_range(1));
    it.timer_expired = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t poll(logic up, logic expired);
    in_item_t it;
    it.action = ACTION_POLL;
    it.dest_port = 16'($urandom);
    it.packet_len = 16'($urandom);
    it.cookie = $urandom;
    it.command = $urandom;
    it.argument = $urandom;
    it.link_up = up;
    it.timer_expired = expired;
    return it;
  endfunction

  // Valid is only dropped when the sender goes idle, so it never falls and rises in one step.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(logic [24:0] buf_bytes, logic [15:0] port);
    cfg_we <= 1'b1;
    cfg_index <= REG_BUFFER_SIZE;
    cfg_data <= buf_bytes;
    @(negedge clk);
    cfg_index <= REG_SERVER_PORT;
    cfg_data <= {9'd0, port};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_buf = buf_bytes;
    cur_port = port;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int          pick;
    int          size_pick;
    logic [15:0] payload;
    logic [31:0] arg;
    in_item_t    it;
    pick = $urandom_range(99);
    size_pick = $urandom_range(99);
    if (size_pick < 88) begin
      payload = 16'($urandom_range(64));
    end else if (size_pick < 97) begin
      payload = 16'($urandom_range(1024, 65));
    end else begin
      payload = 16'($urandom_range(65519, 1025));
    end
    if (pick < 25) begin
      send_item(poll($urandom_range(99) >= 3, 1'($urandom_range(1))));
      return;
    end
    if (pick < 30) begin
      send_item(packet(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom));
      return;
    end
    pick = $urandom_range(99);
    if (!session_open || pick < 6) begin
      it = packet(cur_port, HEADER_BYTES + payload, next_cookie, CMD_SEND_FILE, $urandom);
      if (payload != 0) begin
        session_open = 1'b1;
        gen_offset = '0;
      end
    end else if (pick < 14) begin
      it = last_pkt;
      it.dest_port = cur_port;
      it.packet_len = HEADER_BYTES + payload;
    end else if (pick < 18) begin
      it = packet(cur_port, HEADER_BYTES + payload, next_cookie, CMD_BOOT, $urandom);
    end else if (pick < 21) begin
      it = packet(cur_port, HEADER_BYTES + payload, next_cookie, CMD_COMMAND, $urandom);
    end else if (pick < 24) begin
      it = packet(cur_port, HEADER_BYTES + payload, next_cookie, $urandom, $urandom);
    end else if (pick < 27) begin
      it = packet(cur_port, 16'($urandom_range(15)), next_cookie, CMD_DATA,
                  {7'd0, gen_offset});
    end else begin
      arg = (pick < 92) ? {7'd0, gen_offset} : $urandom;
      it = packet(cur_port, HEADER_BYTES + payload, next_cookie, CMD_DATA, arg);
      if (arg == {7'd0, gen_offset} && cur_buf != 0 &&
          {7'd0, gen_offset} + payload <= {7'd0, cur_buf}) begin
        gen_offset = gen_offset + payload;
      end
    end
    last_pkt = it;
    next_cookie = next_cookie + 1;
    send_item(it);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BUFFER_SIZE;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cur_buf = '0;
    cur_port = SERVER_PORT_RST;
    gen_offset = '0;
    next_cookie = $urandom;
    session_open = 1'b0;
    last_pkt = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(packet(SERVER_PORT_RST, HEADER_BYTES, '0, '0, '0));
    send_item(poll(1'b0, 1'b1));
    send_item(poll(1'b1, 1'b1));
    send_item(poll(1'b1, 1'b0));
    send_item(packet(SERVER_PORT_RST + 16'd1, 16'd40, 32'd7, CMD_BOOT, '0));
    send_item(packet(SERVER_PORT_RST, HEADER_BYTES - 16'd1, 32'd8, CMD_BOOT, '0));
    send_item(packet(SERVER_PORT_RST, HEADER_BYTES, 32'd9, CMD_COMMAND, '0));
    send_item(packet(SERVER_PORT_RST, HEADER_BYTES + 16'd1, 32'd1, CMD_COMMAND, '0));
    send_item(packet(SERVER_PORT_RST, HEADER_BYTES, 32'd10, CMD_SEND_FILE, '0));
    send_item(packet(SERVER_PORT_RST, 16'hFFFF, 32'hFFFF_FFFF, CMD_SEND_FILE, 32'd3));
    send_item(packet(SERVER_PORT_RST, 16'd100, 32'd11, CMD_DATA, '0));
    send_item(packet(SERVER_PORT_RST, 16'd20, 32'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(packet(SERVER_PORT_RST, 16'd30, 32'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(packet(SERVER_PORT_RST, HEADER_BYTES, 32'd5, CMD_BOOT, '0));
    send_item(poll(1'b0, 1'b0));
    send_item(poll(1'b1, 1'b1));
    send_item(poll(1'b0, 1'b0));
    send_item(poll(1'b1, 1'b1));
    settle();

    write_regs(25'd300, 16'd0);
    send_item(packet(16'd0, HEADER_BYTES + 16'd100, 32'd20, CMD_DATA, 32'd0));
    send_item(packet(16'd0, HEADER_BYTES + 16'd10, 32'd21, CMD_DATA, 32'd0));
    send_item(packet(16'd0, HEADER_BYTES + 16'd250, 32'd22, CMD_DATA, 32'd100));
    send_item(packet(16'd0, HEADER_BYTES + 16'd250, 32'd22, CMD_DATA, 32'd100));
    send_item(packet(16'd0, HEADER_BYTES + 16'd200, 32'd23, CMD_DATA, 32'd100));
    send_item(packet(16'd0, HEADER_BYTES, 32'd24, CMD_DATA, 32'd300));
    send_item(packet(16'd0, HEADER_BYTES, 32'd25, CMD_BOOT, 32'd0));
    send_item(poll(1'b1, 1'b0));
    send_item(packet(16'hFFFF, HEADER_BYTES + 16'd4, 32'd26, CMD_COMMAND, 32'd0));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg % 4)
        0: write_regs(25'h100_0000, 16'hFFFF);
        1: write_regs(25'd1, 16'd0);
        2: write_regs(25'($urandom_range(8192, 64)), 16'($urandom));
        default: write_regs('0, SERVER_PORT_RST);
      endcase
      case ((seg / 2) % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      repeat (SEGMENT_ITEMS) send_random_item();
    end
    settle();

    $display("summary: %0d items sent and %0d results checked,", items_sent, checked);
    $display("summary: %0d register settings under four flow-control phases", SEGMENTS + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
